>>> rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Expression must never be true.
`define ASSERT_NEVER(label, clk, rst_n, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define ASSERT_NEVER(label, clk, rst_n, expr)
`endif
`endif

>>> rtl/core/psr_pkg.sv
// ----------------------------------------------------------------------------
// psr_pkg
// Types and constants shared by the slot reservation modules.
// ----------------------------------------------------------------------------
package psr_pkg;

  // Opcodes carried in the input tuser.
  localparam logic [2:0] OP_LOAD_ARC   = 3'd0;
  localparam logic [2:0] OP_LOAD_HOP   = 3'd1;
  localparam logic [2:0] OP_LOAD_COUNT = 3'd2;
  localparam logic [2:0] OP_TEST       = 3'd3;
  localparam logic [2:0] OP_RESERVE    = 3'd4;
  // Spare opcodes; the block rejects them.
  localparam logic [2:0] OP_SPARE0     = 3'd5;
  localparam logic [2:0] OP_SPARE1     = 3'd6;
  localparam logic [2:0] OP_SPARE2     = 3'd7;

  // Register index of the period register.
  localparam logic REG_PERIOD = 1'b0;

  // Field positions in the input tdata.
  localparam int ARC_IDX_LSB = 0;
  localparam int ARC_LEN_LSB = 6;
  localparam int ARC_SH_LSB  = 22;
  localparam int ROUTE_LSB   = 23;
  localparam int HOP_LSB     = 27;
  localparam int COUNT_LSB   = 31;
  localparam int START_LSB   = 36;
  localparam int SIZE_LSB    = 52;

  // Length sum saturation value.
  localparam logic [19:0] LEN_SAT = 20'hFFFFF;

  // Control of one bitmap access.
  typedef struct packed {
    logic we;
    logic back;
  } busy_ctl_t;

  // Sequencer states.
  typedef enum logic [12:0] {
    S_IDLE = 13'b0000000000001,
    S_HOP  = 13'b0000000000010,
    S_ARC  = 13'b0000000000100,
    S_LEN  = 13'b0000000001000,
    S_LMOD = 13'b0000000010000,
    S_STRT = 13'b0000000100000,
    S_SMOD = 13'b0000001000000,
    S_CHK0 = 13'b0000010000000,
    S_CHK1 = 13'b0000100000000,
    S_CHK2 = 13'b0001000000000,
    S_MARK = 13'b0010000000000,
    S_NEXT = 13'b0100000000000,
    S_DONE = 13'b1000000000000
  } state_e;

endpackage

>>> rtl/core/periodic_slot_reservation.sv
// ----------------------------------------------------------------------------
// periodic_slot_reservation
// Route and arc tables with per-arc slot bitmaps; tests and reserves messages.
// ----------------------------------------------------------------------------
// Channel   Dir  Handshake             Content
// s_axis    in   tvalid/tready         command: tuser opcode/flags, tdata operands
// m_axis    out  tvalid/tready         result: tdata fits/total, tuser error
// apb       in   psel/penable/pready   period register at byte address 0
//
// A length query sums the route's arc lengths. Test and reserve reduce the start
// offset and each arc length in the 16-step remainder unit; a test reads both end
// slots at each shared arc, a reserve marks its slots there. After reset a clearing
// pass over all NUM_ARCS*2^ceil(log2 MAX_PERIOD) bitmap entries (65536 by default)
// runs before the first command is taken. One command is in work at a time; its
// result waits in the output register while the next one is accepted.
// ----------------------------------------------------------------------------
module periodic_slot_reservation #(
  parameter int NUM_ARCS   = 64,
  parameter int NUM_ROUTES = 16,
  parameter int MAX_HOPS   = 16,
  parameter int MAX_PERIOD = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // arc_index, arc_length, arc_shared, route_index, hop_index, hop_count,
  // start_offset, msg_slots, zero pad
  input  logic [63:0] s_axis_tdata_i,
  // opcode, op_route_length, backward
  input  logic [4:0]  s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // fits, total_length, zero pad
  output logic [23:0] m_axis_tdata_o,
  // error
  output logic        m_axis_tuser_o,
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic [2:0]  paddr_i,
  input  logic [31:0] pwdata_i,
  output logic [31:0] prdata_o,
  output logic        pready_o
);

  `include "assert_macros.svh"

  localparam int AW = (NUM_ARCS > 1) ? $clog2(NUM_ARCS) : 1;
  localparam int RW = (NUM_ROUTES > 1) ? $clog2(NUM_ROUTES) : 1;
  localparam int HW = (MAX_HOPS > 1) ? $clog2(MAX_HOPS) : 1;
  localparam int CW = $clog2(MAX_HOPS + 1);
  localparam int SW = $clog2(MAX_PERIOD);
  localparam int BAW = AW + SW;
  localparam int BDEPTH = NUM_ARCS * (2 ** SW);
  localparam int HDEPTH = NUM_ROUTES * (2 ** HW);
  localparam logic [10:0] PERIOD_RST = 11'((MAX_PERIOD < 1024) ? MAX_PERIOD : 1024);

  // Input field unpacking.
  logic [2:0]  in_op;
  logic        in_lenq, in_back, in_sh;
  logic [5:0]  in_arc;
  logic [15:0] in_len, in_start;
  logic [3:0]  in_route, in_hop;
  logic [4:0]  in_count;
  logic [10:0] in_size;

  assign in_op    = s_axis_tuser_i[2:0];
  assign in_lenq  = s_axis_tuser_i[3];
  assign in_back  = s_axis_tuser_i[4];
  assign in_arc   = s_axis_tdata_i[psr_pkg::ARC_IDX_LSB +: 6];
  assign in_len   = s_axis_tdata_i[psr_pkg::ARC_LEN_LSB +: 16];
  assign in_sh    = s_axis_tdata_i[psr_pkg::ARC_SH_LSB];
  assign in_route = s_axis_tdata_i[psr_pkg::ROUTE_LSB +: 4];
  assign in_hop   = s_axis_tdata_i[psr_pkg::HOP_LSB +: 4];
  assign in_count = s_axis_tdata_i[psr_pkg::COUNT_LSB +: 5];
  assign in_start = s_axis_tdata_i[psr_pkg::START_LSB +: 16];
  assign in_size  = s_axis_tdata_i[psr_pkg::SIZE_LSB +: 11];

  // Period register.
  logic [10:0] period_q;
  logic        cfg_we;
  logic [10:0] cfg_val;

  assign cfg_we = psel_i && penable_i && pwrite_i && (paddr_i[2] == psr_pkg::REG_PERIOD);

  always_comb begin
    cfg_val = pwdata_i[10:0];
    if (cfg_val == '0) begin
      cfg_val = 11'd1;
    end
    if (32'(cfg_val) > MAX_PERIOD) begin
      cfg_val = 11'(MAX_PERIOD);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= PERIOD_RST;
    end else if (cfg_we) begin
      period_q <= cfg_val;
    end
  end

  assign prdata_o = (paddr_i[2] == psr_pkg::REG_PERIOD) ? {21'd0, period_q} : 32'd0;
  assign pready_o = 1'b1;

  // Sequencer registers.
  psr_pkg::state_e state_q, state_d;
  logic [2:0]  op_q, op_d;
  logic        lenq_q, lenq_d, back_q, back_d;
  logic [RW-1:0] route_q, route_d;
  logic [15:0] start_q, start_d;
  logic [10:0] size_q, size_d;
  logic [CW-1:0] k_q, k_d, n_q, n_d;
  logic [AW-1:0] arc_q, arc_d;
  logic        shared_q, shared_d;
  logic [10:0] off_q, off_d, slot_q, slot_d, left_q, left_d;
  logic        hit_q, hit_d;
  logic [19:0] sum_q, sum_d;
  logic        fits_q, fits_d, err_q, err_d;
  logic        out_vld_q, out_vld_d, out_fits_q, out_err_q;
  logic [19:0] out_total_q;
  logic        out_load;

  // Table storage.
  logic [15:0]   arc_mem [NUM_ARCS];
  logic          arc_sh_mem [NUM_ARCS];
  logic [NUM_ARCS-1:0] arc_vld_q;
  logic [AW-1:0] hop_mem [HDEPTH];
  logic [CW-1:0] count_q [NUM_ROUTES];
  logic [15:0]   arc_rd_len_q;
  logic          arc_rd_sh_q, arc_rd_vld_q;
  logic [AW-1:0] hop_rd_q;

  logic in_fire, arc_we, hop_we, count_we;
  logic arc_ok, route_ok, hop_ok, count_ok;
  logic [RW+HW-1:0] hop_waddr, hop_raddr;
  logic [CW-1:0] pos;
  logic [AW-1:0] in_arc_w;
  logic [RW-1:0] in_route_w;

  logic clr_ready;
  psr_pkg::busy_ctl_t bctl;
  logic [BAW-1:0] baddr;
  logic bdata;

  logic mod_start, mod_done;
  logic [15:0] mod_x;
  logic [10:0] mod_rem;

  logic [11:0] off_sum, off2_sum;
  logic [10:0] off2;
  logic [20:0] len_sum;

  assign s_axis_tready_o = (state_q == psr_pkg::S_IDLE) && clr_ready;
  assign in_fire = s_axis_tvalid_i && s_axis_tready_o;

  assign in_arc_w   = AW'(in_arc);
  assign in_route_w = RW'(in_route);
  assign arc_ok   = 32'(in_arc) < NUM_ARCS;
  assign route_ok = 32'(in_route) < NUM_ROUTES;
  assign hop_ok   = 32'(in_hop) < MAX_HOPS;
  assign count_ok = 32'(in_count) <= MAX_HOPS;

  assign arc_we   = in_fire && (in_op == psr_pkg::OP_LOAD_ARC) && arc_ok;
  assign hop_we   = in_fire && (in_op == psr_pkg::OP_LOAD_HOP) && route_ok && hop_ok && arc_ok;
  assign count_we = in_fire && (in_op == psr_pkg::OP_LOAD_COUNT) && route_ok && count_ok;

  // Hop position: reverse order for backward walks.
  assign pos = (back_q && !lenq_q) ? (n_q - k_q - CW'(1)) : k_q;
  assign hop_waddr = {in_route_w, HW'(in_hop)};
  assign hop_raddr = {route_q, HW'(pos)};

  // Arc memory: length and shared flag, valid bits give the flag its reset.
  always_ff @(posedge clk_i) begin
    if (arc_we) begin
      arc_mem[in_arc_w]    <= in_len;
      arc_sh_mem[in_arc_w] <= in_sh;
    end
    arc_rd_len_q <= arc_mem[hop_rd_q];
    arc_rd_sh_q  <= arc_sh_mem[hop_rd_q];
    arc_rd_vld_q <= arc_vld_q[hop_rd_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      arc_vld_q <= '0;
    end else if (arc_we) begin
      arc_vld_q[in_arc_w] <= 1'b1;
    end
  end

  // Hop memory.
  always_ff @(posedge clk_i) begin
    if (hop_we) begin
      hop_mem[hop_waddr] <= AW'(in_arc);
    end
    hop_rd_q <= hop_mem[hop_raddr];
  end

  // Hop counts.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_ROUTES; i++) begin
        count_q[i] <= '0;
      end
    end else if (count_we) begin
      count_q[in_route_w] <= CW'(in_count);
    end
  end

  // Offset arithmetic: both sums stay below twice the period.
  assign off_sum  = {1'b0, off_q} + {1'b0, mod_rem};
  assign off2_sum = {1'b0, off_q} + {1'b0, size_q} - 12'd1;
  assign off2     = (off2_sum >= {1'b0, period_q}) ? 11'(off2_sum - {1'b0, period_q})
                                                  : off2_sum[10:0];
  assign len_sum  = {1'b0, sum_q} + {5'd0, arc_rd_len_q};

  assign mod_start = (state_q == psr_pkg::S_STRT) || ((state_q == psr_pkg::S_LEN) && !lenq_q);
  assign mod_x     = (state_q == psr_pkg::S_LEN) ? arc_rd_len_q : start_q;

  assign out_load = (state_q == psr_pkg::S_DONE) && (!out_vld_q || m_axis_tready_i);

  // Command sequencer.
  always_comb begin
    state_d  = state_q;
    op_d     = op_q;
    lenq_d   = lenq_q;
    back_d   = back_q;
    route_d  = route_q;
    start_d  = start_q;
    size_d   = size_q;
    k_d      = k_q;
    n_d      = n_q;
    arc_d    = arc_q;
    shared_d = shared_q;
    off_d    = off_q;
    slot_d   = slot_q;
    left_d   = left_q;
    hit_d    = hit_q;
    sum_d    = sum_q;
    fits_d   = fits_q;
    err_d    = err_q;
    bctl.we   = 1'b0;
    bctl.back = back_q;
    baddr     = {arc_q, SW'(off_q)};
    case (state_q)
      psr_pkg::S_IDLE: begin
        if (in_fire) begin
          op_d    = in_op;
          // The length query flag only counts together with the test opcode.
          lenq_d  = in_lenq && (in_op == psr_pkg::OP_TEST);
          back_d  = in_back;
          route_d = in_route_w;
          start_d = in_start;
          size_d  = in_size;
          n_d     = count_q[in_route_w];
          k_d     = '0;
          sum_d   = '0;
          fits_d  = 1'b0;
          err_d   = 1'b0;
          state_d = psr_pkg::S_DONE;
          case (in_op)
            psr_pkg::OP_LOAD_ARC:   err_d = !arc_ok;
            psr_pkg::OP_LOAD_HOP:   err_d = !(route_ok && hop_ok && arc_ok);
            psr_pkg::OP_LOAD_COUNT: err_d = !(route_ok && count_ok);
            psr_pkg::OP_TEST, psr_pkg::OP_RESERVE: begin
              if (!route_ok) begin
                err_d = 1'b1;
              end else if ((in_op == psr_pkg::OP_TEST) && in_lenq) begin
                if (count_q[in_route_w] != '0) begin
                  state_d = psr_pkg::S_HOP;
                end
              end else if ((in_size == '0) || (in_size > period_q)) begin
                err_d = 1'b1;
              end else begin
                fits_d  = (in_op == psr_pkg::OP_TEST);
                state_d = psr_pkg::S_STRT;
              end
            end
            default: err_d = 1'b1;
          endcase
        end
      end
      psr_pkg::S_STRT: begin
        state_d = psr_pkg::S_SMOD;
      end
      psr_pkg::S_SMOD: begin
        if (mod_done) begin
          off_d   = mod_rem;
          state_d = (n_q == '0) ? psr_pkg::S_DONE : psr_pkg::S_HOP;
        end
      end
      psr_pkg::S_HOP: begin
        state_d = psr_pkg::S_ARC;
      end
      psr_pkg::S_ARC: begin
        arc_d   = hop_rd_q;
        state_d = psr_pkg::S_LEN;
      end
      psr_pkg::S_LEN: begin
        shared_d = arc_rd_sh_q && arc_rd_vld_q;
        if (lenq_q) begin
          sum_d   = (len_sum > {1'b0, psr_pkg::LEN_SAT}) ? psr_pkg::LEN_SAT : len_sum[19:0];
          state_d = psr_pkg::S_NEXT;
        end else begin
          state_d = psr_pkg::S_LMOD;
        end
      end
      psr_pkg::S_LMOD: begin
        if (mod_done) begin
          off_d = (off_sum >= {1'b0, period_q}) ? 11'(off_sum - {1'b0, period_q})
                                                : off_sum[10:0];
          slot_d = off_d;
          left_d = size_q;
          if (!shared_q) begin
            state_d = psr_pkg::S_NEXT;
          end else if (op_q == psr_pkg::OP_TEST) begin
            state_d = psr_pkg::S_CHK0;
          end else begin
            state_d = psr_pkg::S_MARK;
          end
        end
      end
      psr_pkg::S_CHK0: begin
        state_d = psr_pkg::S_CHK1;
      end
      psr_pkg::S_CHK1: begin
        baddr   = {arc_q, SW'(off2)};
        hit_d   = bdata;
        state_d = psr_pkg::S_CHK2;
      end
      psr_pkg::S_CHK2: begin
        if (hit_q || bdata) begin
          fits_d  = 1'b0;
          state_d = psr_pkg::S_DONE;
        end else begin
          state_d = psr_pkg::S_NEXT;
        end
      end
      psr_pkg::S_MARK: begin
        bctl.we = 1'b1;
        baddr   = {arc_q, SW'(slot_q)};
        slot_d  = (slot_q + 11'd1 == period_q) ? '0 : slot_q + 11'd1;
        left_d  = left_q - 11'd1;
        if (left_q == 11'd1) begin
          state_d = psr_pkg::S_NEXT;
        end
      end
      psr_pkg::S_NEXT: begin
        k_d     = k_q + CW'(1);
        state_d = (k_q + CW'(1) == n_q) ? psr_pkg::S_DONE : psr_pkg::S_HOP;
      end
      psr_pkg::S_DONE: begin
        if (out_load) begin
          state_d = psr_pkg::S_IDLE;
        end
      end
      default: state_d = psr_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= psr_pkg::S_IDLE;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    lenq_q   <= lenq_d;
    back_q   <= back_d;
    route_q  <= route_d;
    start_q  <= start_d;
    size_q   <= size_d;
    k_q      <= k_d;
    n_q      <= n_d;
    arc_q    <= arc_d;
    shared_q <= shared_d;
    off_q    <= off_d;
    slot_q   <= slot_d;
    left_q   <= left_d;
    hit_q    <= hit_d;
    sum_q    <= sum_d;
    fits_q   <= fits_d;
    err_q    <= err_d;
  end

  // Output register: holds one result until its transfer.
  assign out_vld_d = out_load || (out_vld_q && !m_axis_tready_i);

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_fits_q  <= fits_q;
      out_total_q <= sum_q;
      out_err_q   <= err_q;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {3'd0, out_total_q, out_fits_q};
  assign m_axis_tuser_o  = out_err_q;

  psr_busy #(
    .ADDR_W (BAW),
    .DEPTH  (BDEPTH)
  ) u_busy (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (bctl),
    .addr_i  (baddr),
    .rdata_o (bdata),
    .ready_o (clr_ready)
  );

  psr_modu u_modu (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mod_start),
    .x_i     (mod_x),
    .p_i     (period_q),
    .done_o  (mod_done),
    .rem_o   (mod_rem)
  );

  // Assertions.
  `ASSERT_NEVER(a_no_accept_in_clear, clk_i, rst_ni, s_axis_tready_o && !clr_ready)
  `ASSERT_IMPLY(a_err_no_fit, clk_i, rst_ni, m_axis_tvalid_o && m_axis_tuser_o, !m_axis_tdata_o[0])
  `ASSERT_IMPLY(a_slot_range, clk_i, rst_ni, state_q == psr_pkg::S_MARK, slot_q < period_q)
  `ASSERT_IMPLY(a_walk_bound, clk_i, rst_ni, state_q == psr_pkg::S_HOP, k_q < n_q)

endmodule

>>> rtl/core/psr_modu.sv
// ----------------------------------------------------------------------------
// psr_modu
// Iterative restoring remainder of a 16-bit value by the period, one bit a cycle.
// ----------------------------------------------------------------------------
module psr_modu (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [15:0] x_i,
  input  logic [10:0] p_i,
  output logic        done_o,
  output logic [10:0] rem_o
);

  logic [15:0] x_q, x_d;
  logic [11:0] rem_q, rem_d;
  logic [4:0]  cnt_q, cnt_d;
  logic        done_q, done_d;
  logic [11:0] trial;

  // Shift in the next dividend bit and subtract the period when it fits.
  always_comb begin
    trial  = {rem_q[10:0], x_q[15]};
    x_d    = x_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (start_i) begin
      x_d   = x_i;
      rem_d = '0;
      cnt_d = 5'd16;
    end else if (cnt_q != '0) begin
      x_d   = {x_q[14:0], 1'b0};
      rem_d = (trial >= {1'b0, p_i}) ? trial - {1'b0, p_i} : trial;
      cnt_d = cnt_q - 5'd1;
      done_d = (cnt_q == 5'd1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q   <= x_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q[10:0];

endmodule

>>> rtl/core/psr_busy.sv
// ----------------------------------------------------------------------------
// psr_busy
// Forward and backward slot bitmaps with a clearing pass after reset.
// ----------------------------------------------------------------------------
module psr_busy #(
  parameter int ADDR_W = 16,
  parameter int DEPTH  = 65536
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  psr_pkg::busy_ctl_t  ctl_i,
  input  logic [ADDR_W-1:0]   addr_i,
  output logic                rdata_o,
  output logic                ready_o
);

  logic fwd_mem [DEPTH];
  logic bwd_mem [DEPTH];
  logic [ADDR_W-1:0] clr_addr_q;
  logic              clr_q;
  logic [ADDR_W-1:0] addr;
  logic              fwd_we, bwd_we, wval;
  logic              fwd_rd_q, bwd_rd_q, back_q;

  // Clearing pass walks every entry once after reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q      <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_q) begin
      clr_addr_q <= clr_addr_q + 1'b1;
      if (clr_addr_q == ADDR_W'(DEPTH - 1)) begin
        clr_q <= 1'b0;
      end
    end
  end

  always_comb begin
    addr   = clr_q ? clr_addr_q : addr_i;
    wval   = !clr_q;
    fwd_we = clr_q || (ctl_i.we && !ctl_i.back);
    bwd_we = clr_q || (ctl_i.we && ctl_i.back);
  end

  always_ff @(posedge clk_i) begin
    if (fwd_we) begin
      fwd_mem[addr] <= wval;
    end
    fwd_rd_q <= fwd_mem[addr];
  end

  always_ff @(posedge clk_i) begin
    if (bwd_we) begin
      bwd_mem[addr] <= wval;
    end
    bwd_rd_q <= bwd_mem[addr];
  end

  always_ff @(posedge clk_i) begin
    back_q <= ctl_i.back;
  end

  assign rdata_o = back_q ? bwd_rd_q : fwd_rd_q;
  assign ready_o = !clr_q;

endmodule

>>> dv/periodic_slot_reservation_tb.sv
// ----------------------------------------------------------------------------
// periodic_slot_reservation_tb
// Self-checking bench: drives commands on the input stream, writes the period
// over APB between phases, predicts each result and compares it on the output.
// ----------------------------------------------------------------------------
module periodic_slot_reservation_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ARCS       = 64;
  localparam int ROUTES     = 16;
  localparam int HOPS       = 16;
  localparam int PERIOD_MAX = 1024;
  localparam int STALL_LIMIT = 200000;
  localparam int HOLD_CYCLES = 3000;

  typedef struct {
    bit        fits;
    bit [19:0] total;
    bit        err;
  } slot_result_t;

  // Shadow copy of the tables and bitmaps with the expected result queue.
  class slot_scoreboard;
    bit [15:0]    arc_len [ARCS];
    bit           arc_sh  [ARCS];
    bit           arc_set [ARCS];
    bit [5:0]     hop_tab [ROUTES*HOPS];
    bit           hop_set [ROUTES*HOPS];
    bit [4:0]     hop_cnt [ROUTES];
    bit           fwd_busy [ARCS*PERIOD_MAX];
    bit           bwd_busy [ARCS*PERIOD_MAX];
    int unsigned  period;
    slot_result_t result_q[$];
    int           errors;

    function new();
      period = PERIOD_MAX;
    endfunction

    function void set_period(int unsigned v);
      v = v & 32'h7FF;
      if (v == 0) v = 1;
      if (v > PERIOD_MAX) v = PERIOD_MAX;
      period = v;
    endfunction

    // First hop position of the route that was never loaded, or -1.
    function int missing_hop(int unsigned r);
      for (int k = 0; k < hop_cnt[r]; k++)
        if (!hop_set[r*HOPS+k]) return k;
      return -1;
    endfunction

    // First arc on the route whose length was never loaded, or -1.
    function int missing_arc(int unsigned r);
      for (int k = 0; k < hop_cnt[r]; k++)
        if (!arc_set[hop_tab[r*HOPS+k]]) return int'(hop_tab[r*HOPS+k]);
      return -1;
    endfunction

    // Walks the hops, either testing the end slots or marking the message.
    function bit walk_route(int unsigned r, int unsigned off, int unsigned size,
                            bit back, bit mark);
      int unsigned n, a, pos, base;
      n = 32'(hop_cnt[r]);
      for (int unsigned k = 0; k < n; k++) begin
        pos  = back ? (n - 1 - k) : k;
        a    = 32'(hop_tab[r*HOPS+pos]);
        off  = (off + 32'(arc_len[a]) % period) % period;
        base = a * PERIOD_MAX;
        if (!arc_sh[a]) continue;
        if (mark) begin
          for (int unsigned j = 0; j < size; j++) begin
            if (back) bwd_busy[base + (off + j) % period] = 1'b1;
            else      fwd_busy[base + (off + j) % period] = 1'b1;
          end
        end else if (back) begin
          if (bwd_busy[base + off] || bwd_busy[base + (off + size - 1) % period]) return 0;
        end else begin
          if (fwd_busy[base + off] || fwd_busy[base + (off + size - 1) % period]) return 0;
        end
      end
      return 1;
    endfunction

    // Applies one accepted command and queues its result.
    function void note_command(logic [63:0] d, logic [4:0] u);
      logic [2:0]   op;
      int unsigned  arc, route, hop, cnt, start, size, sum;
      bit           lenq, back;
      slot_result_t res;
      op    = u[2:0];
      lenq  = u[3];
      back  = u[4];
      arc   = 32'(d[psr_pkg::ARC_IDX_LSB +: 6]);
      route = 32'(d[psr_pkg::ROUTE_LSB +: 4]);
      hop   = 32'(d[psr_pkg::HOP_LSB +: 4]);
      cnt   = 32'(d[psr_pkg::COUNT_LSB +: 5]);
      start = 32'(d[psr_pkg::START_LSB +: 16]);
      size  = 32'(d[psr_pkg::SIZE_LSB +: 11]);
      res   = '{fits: 1'b0, total: 20'd0, err: 1'b0};
      case (op)
        psr_pkg::OP_LOAD_ARC: begin
          arc_len[arc] = d[psr_pkg::ARC_LEN_LSB +: 16];
          arc_sh[arc]  = d[psr_pkg::ARC_SH_LSB];
          arc_set[arc] = 1'b1;
        end
        psr_pkg::OP_LOAD_HOP: begin
          hop_tab[route*HOPS+hop] = 6'(arc);
          hop_set[route*HOPS+hop] = 1'b1;
        end
        psr_pkg::OP_LOAD_COUNT: begin
          if (cnt > HOPS) res.err = 1'b1;
          else hop_cnt[route] = 5'(cnt);
        end
        psr_pkg::OP_TEST, psr_pkg::OP_RESERVE: begin
          if (op == psr_pkg::OP_TEST && lenq) begin
            sum = 0;
            for (int k = 0; k < hop_cnt[route]; k++) begin
              sum += 32'(arc_len[hop_tab[route*HOPS+k]]);
              if (sum > 32'(psr_pkg::LEN_SAT)) sum = 32'(psr_pkg::LEN_SAT);
            end
            res.total = 20'(sum);
          end else if (size == 0 || size > period) begin
            res.err = 1'b1;
          end else if (op == psr_pkg::OP_TEST) begin
            res.fits = walk_route(route, start % period, size, back, 1'b0);
          end else begin
            void'(walk_route(route, start % period, size, back, 1'b1));
          end
        end
        default: res.err = 1'b1;
      endcase
      result_q.push_back(res);
    endfunction

    task report_mismatch(string what);
      $display("mismatch at %0t: %s", $realtime, what);
      errors++;
    endtask

    // Compares one result transfer with the oldest prediction.
    task check_result(logic [23:0] d, logic u);
      slot_result_t exp_r;
      if (result_q.size() == 0) begin
        report_mismatch("result transfer with nothing predicted");
        return;
      end
      exp_r = result_q.pop_front();
      if (d[0] !== exp_r.fits)
        report_mismatch($sformatf("fits %b, predicted %b", d[0], exp_r.fits));
      if (d[20:1] !== exp_r.total)
        report_mismatch($sformatf("total_length %0d, predicted %0d", d[20:1], exp_r.total));
      if (u !== exp_r.err)
        report_mismatch($sformatf("error %b, predicted %b", u, exp_r.err));
    endtask
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_valid;
  logic [63:0] s_data;
  logic [4:0]  s_user;
  logic        m_ready;
  logic        psel, penable, pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic        s_axis_tready_o, m_axis_tvalid_o, m_axis_tuser_o, pready_o;
  logic [23:0] m_axis_tdata_o;
  logic [31:0] prdata_o;

  slot_scoreboard sb = new();
  int send_idle = 0;
  int recv_idle = 20;
  bit hold_req  = 1'b0;
  int hold_left = 0;
  int stall_cnt = 0;

  periodic_slot_reservation dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .psel_i          (psel),
    .penable_i       (penable),
    .pwrite_i        (pwrite),
    .paddr_i         (paddr),
    .pwdata_i        (pwdata),
    .prdata_o        (prdata_o),
    .pready_o        (pready_o)
  );

  always #6 clk_i = ~clk_i;

  // Transfers are sampled mid-cycle, where every signal is settled.
  always @(negedge clk_i) begin
    if (rst_ni && s_valid && s_axis_tready_o) sb.note_command(s_data, s_user);
    if (rst_ni && m_axis_tvalid_o && m_ready) sb.check_result(m_axis_tdata_o, m_axis_tuser_o);
  end

  // Watchdog on cycles without any transfer.
  always @(negedge clk_i) begin
    if ((s_valid && s_axis_tready_o) || (m_axis_tvalid_o && m_ready)) stall_cnt = 0;
    else stall_cnt++;
    if (stall_cnt >= STALL_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Result receiver with random back-pressure and one long hold-off.
  always @(posedge clk_i) begin
    if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_ready <= 1'b0;
    end else begin
      m_ready <= ($urandom_range(0, 99) >= recv_idle);
    end
  end

  // Offers one command and returns right after the edge that takes it.
  task send_command(logic [63:0] d, logic [4:0] u);
    bit taken;
    while ($urandom_range(0, 99) < send_idle) begin
      s_valid <= 1'b0;
      @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_data  <= d;
    s_user  <= u;
    do begin
      @(negedge clk_i);
      taken = s_axis_tready_o;
      @(posedge clk_i);
    end while (!taken);
  endtask

  function automatic logic [63:0] pack_fields(int arc, int alen, bit sh, int route, int hop,
                                              int cnt, int start, int size);
    logic [63:0] d;
    d = '0;
    d[psr_pkg::ARC_IDX_LSB +: 6]  = 6'(arc);
    d[psr_pkg::ARC_LEN_LSB +: 16] = 16'(alen);
    d[psr_pkg::ARC_SH_LSB]        = sh;
    d[psr_pkg::ROUTE_LSB +: 4]    = 4'(route);
    d[psr_pkg::HOP_LSB +: 4]      = 4'(hop);
    d[psr_pkg::COUNT_LSB +: 5]    = 5'(cnt);
    d[psr_pkg::START_LSB +: 16]   = 16'(start);
    d[psr_pkg::SIZE_LSB +: 11]    = 11'(size);
    return d;
  endfunction

  task send_op(logic [2:0] op, bit lenq, bit back, logic [63:0] d);
    send_command(d, {back, lenq, op});
  endtask

  // Random command; walks over routes with unloaded entries become loads.
  task send_random;
    logic [63:0] d;
    logic [2:0]  op;
    int          pick, r, miss, lim;
    bit          lenq;
    d    = {$urandom, $urandom};
    d[63] = 1'b0;
    lenq = $urandom_range(0, 9) == 0;
    pick = $urandom_range(0, 99);
    r    = int'(d[psr_pkg::ROUTE_LSB +: 4]);
    if (pick < 10) op = psr_pkg::OP_LOAD_ARC;
    else if (pick < 25) op = psr_pkg::OP_LOAD_HOP;
    else if (pick < 35) op = psr_pkg::OP_LOAD_COUNT;
    else if (pick < 65) op = psr_pkg::OP_TEST;
    else if (pick < 95) op = psr_pkg::OP_RESERVE;
    else if (pick < 97) op = psr_pkg::OP_SPARE0;
    else if (pick < 99) op = psr_pkg::OP_SPARE1;
    else op = psr_pkg::OP_SPARE2;
    case (op)
      psr_pkg::OP_LOAD_ARC: begin
        pick = $urandom_range(0, 9);
        if (pick < 5) begin
          d[psr_pkg::ARC_LEN_LSB +: 16] = 16'($urandom_range(0, 40));
        end else if (pick == 9) begin
          d[psr_pkg::ARC_LEN_LSB +: 16] = {16{$urandom_range(0, 1) == 1}};
        end
      end
      psr_pkg::OP_LOAD_COUNT: begin
        if ($urandom_range(0, 9) != 0) begin
          d[psr_pkg::COUNT_LSB +: 5] = 5'($urandom_range(0, HOPS));
        end
      end
      psr_pkg::OP_TEST, psr_pkg::OP_RESERVE: begin
        lim  = (sb.period < 16) ? int'(sb.period) : 16;
        pick = $urandom_range(0, 19);
        if (pick == 0) begin
          d[psr_pkg::SIZE_LSB +: 11] = $urandom_range(0, 1) ? 11'd0
                                       : 11'($urandom_range(sb.period + 1, 2047));
        end else if (pick == 1) begin
          d[psr_pkg::SIZE_LSB +: 11] = 11'($urandom_range(1, sb.period));
        end else begin
          d[psr_pkg::SIZE_LSB +: 11] = 11'($urandom_range(1, lim));
        end
        miss = sb.missing_hop(r);
        if (miss >= 0) begin
          op = psr_pkg::OP_LOAD_HOP;
          d[psr_pkg::HOP_LSB +: 4] = 4'(miss);
        end else begin
          miss = sb.missing_arc(r);
          if (miss >= 0) begin
            op = psr_pkg::OP_LOAD_ARC;
            d[psr_pkg::ARC_IDX_LSB +: 6] = 6'(miss);
            d[psr_pkg::ARC_LEN_LSB +: 16] = 16'($urandom_range(0, 40));
          end
        end
      end
      default: ;
    endcase
    send_op(op, lenq, d[63] ^ 1'($urandom_range(0, 1)), d);
  endtask

  task apb_write(logic [31:0] v);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= '0;
    pwdata  <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(negedge clk_i); while (!pready_o);
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    sb.set_period(v);
  endtask

  task wait_drained;
    s_valid <= 1'b0;
    while (sb.result_q.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  int phase_period[9] = '{37, 1, 0, 2047, 1024, 6, 200, 1024, 16};

  initial begin
    rst_ni  <= 1'b0;
    s_valid <= 1'b0;
    s_data  <= '0;
    s_user  <= '0;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= '0;
    pwdata  <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed commands at the reset period.
    send_op(psr_pkg::OP_LOAD_ARC, 1'b0, 1'b0, pack_fields(0, 65535, 1, 0, 0, 0, 0, 0));
    send_op(psr_pkg::OP_LOAD_ARC, 1'b0, 1'b0, pack_fields(63, 0, 1, 0, 0, 0, 0, 0));
    send_op(psr_pkg::OP_LOAD_ARC, 1'b0, 1'b0, pack_fields(5, 3, 0, 0, 0, 0, 0, 0));
    send_op(psr_pkg::OP_LOAD_HOP, 1'b0, 1'b0, pack_fields(0, 0, 0, 0, 0, 0, 0, 0));
    send_op(psr_pkg::OP_LOAD_HOP, 1'b0, 1'b0, pack_fields(63, 0, 0, 0, 1, 0, 0, 0));
    send_op(psr_pkg::OP_LOAD_HOP, 1'b0, 1'b0, pack_fields(5, 0, 0, 0, 15, 0, 0, 0));
    send_op(psr_pkg::OP_LOAD_HOP, 1'b0, 1'b0, pack_fields(63, 0, 0, 15, 0, 0, 0, 0));
    send_op(psr_pkg::OP_LOAD_COUNT, 1'b0, 1'b0, pack_fields(0, 0, 0, 0, 0, 2, 0, 0));
    send_op(psr_pkg::OP_LOAD_COUNT, 1'b0, 1'b0, pack_fields(0, 0, 0, 15, 0, 1, 0, 0));
    // Hop counts above the maximum are rejected.
    send_op(psr_pkg::OP_LOAD_COUNT, 1'b0, 1'b0, pack_fields(0, 0, 0, 1, 0, 17, 0, 0));
    send_op(psr_pkg::OP_LOAD_COUNT, 1'b0, 1'b0, pack_fields(0, 0, 0, 2, 0, 31, 0, 0));
    send_op(psr_pkg::OP_TEST, 1'b1, 1'b0, pack_fields(0, 0, 0, 0, 0, 0, 0, 0));
    send_op(psr_pkg::OP_TEST, 1'b0, 1'b0, pack_fields(0, 0, 0, 0, 0, 0, 65535, 1024));
    send_op(psr_pkg::OP_RESERVE, 1'b0, 1'b0, pack_fields(0, 0, 0, 0, 0, 0, 0, 1));
    send_op(psr_pkg::OP_TEST, 1'b0, 1'b0, pack_fields(0, 0, 0, 0, 0, 0, 0, 1));
    send_op(psr_pkg::OP_TEST, 1'b0, 1'b1, pack_fields(0, 0, 0, 0, 0, 0, 0, 1));
    send_op(psr_pkg::OP_RESERVE, 1'b0, 1'b1, pack_fields(0, 0, 0, 0, 0, 0, 100, 1024));
    send_op(psr_pkg::OP_TEST, 1'b0, 1'b1, pack_fields(0, 0, 0, 0, 0, 0, 100, 2));
    // A reserve with the length query flag still reserves.
    send_op(psr_pkg::OP_RESERVE, 1'b1, 1'b0, pack_fields(0, 0, 0, 0, 0, 0, 500, 3));
    send_op(psr_pkg::OP_TEST, 1'b0, 1'b0, pack_fields(0, 0, 0, 0, 0, 0, 500, 1));
    // Zero size and size beyond the period are rejected.
    send_op(psr_pkg::OP_TEST, 1'b0, 1'b0, pack_fields(0, 0, 0, 0, 0, 0, 0, 0));
    send_op(psr_pkg::OP_RESERVE, 1'b0, 1'b0, pack_fields(0, 0, 0, 0, 0, 0, 0, 1025));
    // Unused opcodes.
    send_op(psr_pkg::OP_SPARE0, 1'b0, 1'b0, pack_fields(0, 0, 0, 0, 0, 0, 0, 1));
    send_op(psr_pkg::OP_SPARE1, 1'b1, 1'b1, pack_fields(0, 0, 0, 0, 0, 0, 0, 1));
    send_op(psr_pkg::OP_SPARE2, 1'b0, 1'b0, pack_fields(0, 0, 0, 0, 0, 0, 0, 1));
    send_op(psr_pkg::OP_TEST, 1'b1, 1'b0, pack_fields(0, 0, 0, 3, 0, 0, 0, 0));
    send_op(psr_pkg::OP_RESERVE, 1'b0, 1'b0, pack_fields(0, 0, 0, 15, 0, 0, 9, 7));
    wait_drained();

    // Random phases, each after a period write; the idling pattern changes every three phases.
    for (int p = 0; p < 9; p++) begin
      apb_write(phase_period[p]);
      case (p / 3)
        0: begin send_idle = 7;  recv_idle = 79; end
        1: begin send_idle = 79; recv_idle = 7;  end
        default: begin send_idle = 0; recv_idle = 0; end
      endcase
      if (p == 6) hold_req = 1'b1;
      for (int i = 0; i < 115; i++) send_random();
      wait_drained();
    end

    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
